[src/mchw_pkg.sv]
// Shared types and constants for the multi-channel heartbeat watchdog.
package mchw_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int SLOT_ID_W   = 4;
    localparam int STATUS_W    = 3;
    localparam int FAILS_W     = 8;
    localparam int SINCE_W     = 16;
    localparam int TOTAL_W     = 32;
    localparam int REP_ID_W    = 16;
    localparam int REQ_TYPE_W  = 3;
    localparam int LIMIT_W     = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 8;
    localparam int OUT_DATA_W = 64;

    localparam logic [REQ_TYPE_W-1:0] REQ_REGISTER = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_TICK     = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_RESTART  = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_CHECK    = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_SET_STAT = 3'd4;

    localparam logic [STATUS_W-1:0] ST_STARTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STALE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_KILLED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DEAD    = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_TICK_LIMIT   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FAILURES = 1'd1;

    localparam logic [LIMIT_W-1:0] TICK_LIMIT_RESET   = 16'd100;
    localparam logic [FAILS_W-1:0] MAX_FAILURES_RESET = 8'd5;

    typedef struct packed {
        logic                attached;
        logic [STATUS_W-1:0] status;
        logic [FAILS_W-1:0]  fails;
        logic [SINCE_W-1:0]  since_check;
        logic [TOTAL_W-1:0]  total;
    } entry_t;

    typedef struct packed {
        logic                found;
        logic [STATUS_W-1:0] status;
        logic [FAILS_W-1:0]  fails;
        logic [SINCE_W-1:0]  since_check;
        logic [TOTAL_W-1:0]  total;
        logic                warning;
        logic                restarted;
    } result_t;

endpackage

[src/multi_channel_heartbeat_watchdog_core.sv]
// Top level of the multi-channel heartbeat watchdog: slot table, request and result stages.
//
// Usage: requests enter on the s_ group (tuser = request type, tdata = slot id,
// reported id, attached flag, new status). Each request yields exactly one result
// record on the m_ group, in request order. Configuration (tick limit, max
// failures) is written through cfg_we / cfg_index / cfg_wdata while idle.
//
// An accepted request passes through the request register, then through the slot
// read-modify-write into the result register, which drives m_tvalid.
// Throughput: one request per cycle while the receiver does not stall; the slot
// table is updated in the same cycle that the result register loads, so
// back-to-back requests to one slot see the previous update.
//
// Reset: all slots become unregistered, tick limit 100, max failures 5, both
// stages empty. When the receiver stalls the result register holds and the
// request register fills; s_tready drops only when both are occupied.
module multi_channel_heartbeat_watchdog_core #(
    parameter int SLOTS = mchw_pkg::SLOTS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [3:0] slot_id, [19:4] reported_id, [20] module_attached, [23:21] new_status
    input  logic [mchw_pkg::IN_DATA_W-1:0]      s_tdata,
    // [2:0] req_type, [7:3] zero
    input  logic [mchw_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] found, [3:1] slot_status, [11:4] fail_count, [27:12] ticks_since_check,
    // [59:28] ticks_total, [60] warning, [61] restarted, [63:62] zero
    output logic [mchw_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [mchw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mchw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // slot ids are 4 bits, so no more than 16 entries are ever reachable
    localparam int IDS   = 1 << mchw_pkg::SLOT_ID_W;
    localparam int DEPTH = (SLOTS < IDS) ? SLOTS : IDS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [mchw_pkg::FAILS_W-1:0] FAILS_MAX = '1;
    localparam logic [mchw_pkg::SINCE_W-1:0] SINCE_MAX = '1;
    localparam logic [mchw_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

    logic [mchw_pkg::LIMIT_W-1:0]    tick_limit_reg;
    logic [mchw_pkg::FAILS_W-1:0]    max_failures_reg;

    logic                            in_valid_reg;
    logic [mchw_pkg::REQ_TYPE_W-1:0] in_type_reg;
    logic [mchw_pkg::IN_DATA_W-1:0]  in_data_reg;

    logic                            out_valid_reg;
    mchw_pkg::result_t               out_reg;
    mchw_pkg::result_t               out_next;

    logic                            valid_reg [DEPTH];
    mchw_pkg::entry_t                rec_reg [DEPTH];
    mchw_pkg::entry_t                rec_next;
    logic                            rec_we;

    logic                            advance;

    logic [mchw_pkg::SLOT_ID_W-1:0]  f_slot;
    logic [mchw_pkg::REP_ID_W-1:0]   f_rep;
    logic                            f_attach;
    logic [mchw_pkg::STATUS_W-1:0]   f_nst;
    logic [IDX_W-1:0]                idx;
    logic                            in_range;
    logic                            slot_found;
    mchw_pkg::entry_t                base;
    logic [mchw_pkg::FAILS_W-1:0]    fails_bumped;
    logic                            warn;
    logic                            restart;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign f_slot   = in_data_reg[3:0];
    assign f_rep    = in_data_reg[19:4];
    assign f_attach = in_data_reg[20];
    assign f_nst    = in_data_reg[23:21];
    assign idx      = IDX_W'(f_slot);
    assign in_range = (32'(f_slot) < SLOTS);

    always_comb
    begin
        slot_found   = in_range && (valid_reg[idx] || in_type_reg == mchw_pkg::REQ_REGISTER);
        base         = rec_reg[idx];
        if (in_type_reg == mchw_pkg::REQ_REGISTER)
        begin
            base.attached    = f_attach;
            base.status      = mchw_pkg::ST_STARTED;
            base.fails       = '0;
            base.since_check = '0;
            base.total       = '0;
        end
        fails_bumped = (base.fails == FAILS_MAX) ? FAILS_MAX : base.fails + 1'b1;
        rec_next     = base;
        warn         = 1'b0;
        restart      = 1'b0;
        case (in_type_reg)
            mchw_pkg::REQ_TICK:
            begin
                if (base.total != TOTAL_MAX)
                    rec_next.total = base.total + 1'b1;
                if (base.since_check != SINCE_MAX)
                    rec_next.since_check = base.since_check + 1'b1;
            end
            mchw_pkg::REQ_RESTART:
            begin
                rec_next.status      = mchw_pkg::ST_STARTED;
                rec_next.fails       = '0;
                rec_next.since_check = '0;
            end
            mchw_pkg::REQ_CHECK:
            begin
                if (base.attached)
                begin
                    if (f_rep != mchw_pkg::REP_ID_W'(f_slot))
                    begin
                        rec_next.fails  = fails_bumped;
                        rec_next.status = mchw_pkg::ST_STALE;
                    end
                    else if (base.since_check <= tick_limit_reg)
                    begin
                        rec_next.fails  = '0;
                        rec_next.status = mchw_pkg::ST_OK;
                    end
                    else
                    begin
                        rec_next.fails  = fails_bumped;
                        rec_next.status = mchw_pkg::ST_STALE;
                        warn            = 1'b1;
                    end
                    rec_next.since_check = '0;
                    if (rec_next.fails >= max_failures_reg)
                    begin
                        rec_next.status = mchw_pkg::ST_STARTED;
                        rec_next.fails  = '0;
                        restart         = 1'b1;
                    end
                end
            end
            mchw_pkg::REQ_SET_STAT:
            begin
                if (f_nst <= mchw_pkg::ST_DEAD)
                    rec_next.status = f_nst;
            end
            default:
            begin
                rec_next = base;
            end
        endcase

        rec_we = advance && slot_found;

        if (slot_found)
        begin
            out_next.found       = 1'b1;
            out_next.status      = rec_next.status;
            out_next.fails       = rec_next.fails;
            out_next.since_check = rec_next.since_check;
            out_next.total       = rec_next.total;
            out_next.warning     = warn;
            out_next.restarted   = restart;
        end
        else
        begin
            out_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_limit_reg   <= mchw_pkg::TICK_LIMIT_RESET;
            max_failures_reg <= mchw_pkg::MAX_FAILURES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mchw_pkg::CFG_TICK_LIMIT:   tick_limit_reg   <= cfg_wdata;
                mchw_pkg::CFG_MAX_FAILURES: max_failures_reg <= cfg_wdata[mchw_pkg::FAILS_W-1:0];
                default:                    tick_limit_reg   <= tick_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_type_reg <= s_tuser[mchw_pkg::REQ_TYPE_W-1:0];
            in_data_reg <= s_tdata;
        end
        if (advance)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (rec_we)
        begin
            valid_reg[idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
            rec_reg[idx] <= rec_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.restarted, out_reg.warning, out_reg.total,
                       out_reg.since_check, out_reg.fails, out_reg.status, out_reg.found};

`ifndef SYNTHESIS
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.restarted) |->
            (out_reg.status == mchw_pkg::ST_STARTED && out_reg.fails == '0
             && out_reg.since_check == '0))
        else $error("restarted result without cleared record");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.found) |-> (m_tdata == '0))
        else $error("not-found result carries nonzero fields");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.warning && !out_reg.found))
        else $error("warning on unregistered slot");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("request side stalled with empty result register");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("result lost during stall");
`endif

endmodule

[tb/sv/multi_channel_heartbeat_watchdog_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the heartbeat watchdog core: random and directed requests.
module multi_channel_heartbeat_watchdog_core_tb;
    import mchw_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int unsigned SEG_ITEMS   = 250;
    localparam int unsigned MAX_REPORTS = 10;
    localparam logic [2:0]  CODE_MAX    = 3'd7;

    typedef struct {
        logic [REQ_TYPE_W-1:0] kind;
        logic [SLOT_ID_W-1:0]  slot;
        logic [REP_ID_W-1:0]   rep_id;
        logic                  attach;
        logic [STATUS_W-1:0]   new_st;
    } request_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic [IN_USER_W-1:0]   s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    request_t pending_requests[$];
    result_t  expected_records[$];
    request_t on_bus;
    bit       holding = 1'b0;
    int unsigned send_idle_pct = 20;
    int unsigned recv_idle_pct = 70;
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count = 0;

    // predictor copy of the slot table and configuration
    logic                 slot_live   [16];
    logic                 slot_attach [16];
    logic [STATUS_W-1:0]  slot_status [16];
    logic [FAILS_W-1:0]   slot_fails  [16];
    logic [SINCE_W-1:0]   slot_since  [16];
    logic [TOTAL_W-1:0]   slot_total  [16];
    logic [LIMIT_W-1:0]   tick_limit_cfg = TICK_LIMIT_RESET;
    logic [FAILS_W-1:0]   max_fail_cfg   = MAX_FAILURES_RESET;

    multi_channel_heartbeat_watchdog_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    function automatic void bump_fails(logic [SLOT_ID_W-1:0] s);
        if (slot_fails[s] != '1)
            slot_fails[s] = slot_fails[s] + 1'b1;
    endfunction

    function automatic result_t next_slot_record(request_t r);
        result_t rec;
        logic [SLOT_ID_W-1:0] s;
        logic warn;
        logic restart;
        rec = '0;
        s = r.slot;
        warn = 1'b0;
        restart = 1'b0;
        if (r.kind == REQ_REGISTER)
        begin
            slot_live[s]   = 1'b1;
            slot_attach[s] = r.attach;
            slot_status[s] = ST_STARTED;
            slot_fails[s]  = '0;
            slot_since[s]  = '0;
            slot_total[s]  = '0;
        end
        if (!slot_live[s])
            return rec;
        case (r.kind)
            REQ_TICK:
            begin
                if (slot_total[s] != '1)
                    slot_total[s] = slot_total[s] + 1'b1;
                if (slot_since[s] != '1)
                    slot_since[s] = slot_since[s] + 1'b1;
            end
            REQ_RESTART:
            begin
                slot_status[s] = ST_STARTED;
                slot_fails[s]  = '0;
                slot_since[s]  = '0;
            end
            REQ_CHECK:
            begin
                if (slot_attach[s])
                begin
                    if (r.rep_id != {{(REP_ID_W-SLOT_ID_W){1'b0}}, s})
                    begin
                        bump_fails(s);
                        slot_status[s] = ST_STALE;
                    end
                    else if (slot_since[s] <= tick_limit_cfg)
                    begin
                        slot_status[s] = ST_OK;
                        slot_fails[s]  = '0;
                    end
                    else
                    begin
                        bump_fails(s);
                        slot_status[s] = ST_STALE;
                        warn = 1'b1;
                    end
                    if (slot_fails[s] >= max_fail_cfg)
                    begin
                        slot_status[s] = ST_STARTED;
                        slot_fails[s]  = '0;
                        slot_since[s]  = '0;
                        restart = 1'b1;
                    end
                    else
                        slot_since[s] = '0;
                end
            end
            REQ_SET_STAT:
            begin
                if (r.new_st <= ST_DEAD)
                    slot_status[s] = r.new_st;
            end
            default: ;
        endcase
        rec.found       = 1'b1;
        rec.status      = slot_status[s];
        rec.fails       = slot_fails[s];
        rec.since_check = slot_since[s];
        rec.total       = slot_total[s];
        rec.warning     = warn;
        rec.restarted   = restart;
        return rec;
    endfunction

    task automatic note_error(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
            note_error($sformatf("result %0d: %s expected 0x%0h got 0x%0h",
                                 results_seen, name, want, got));
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_records.push_back(next_slot_record(on_bus));
                holding = 1'b0;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_bus = pending_requests.pop_front();
                    holding = 1'b1;
                    s_tdata  <= {on_bus.new_st, on_bus.attach, on_bus.rep_id, on_bus.slot};
                    s_tuser  <= {{(IN_USER_W-REQ_TYPE_W){1'b0}}, on_bus.kind};
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_records.size() == 0)
                    note_error($sformatf("result %0d arrived with no request outstanding: 0x%0h",
                                         results_seen, m_tdata));
                else
                begin
                    want = expected_records.pop_front();
                    check_field("found", want.found, m_tdata[0]);
                    check_field("slot_status", want.status, m_tdata[3:1]);
                    check_field("fail_count", want.fails, m_tdata[11:4]);
                    check_field("ticks_since_check", want.since_check, m_tdata[27:12]);
                    check_field("ticks_total", want.total, m_tdata[59:28]);
                    check_field("warning", want.warning, m_tdata[60]);
                    check_field("restarted", want.restarted, m_tdata[61]);
                end
                results_seen++;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("multi_channel_heartbeat_watchdog_core_tb: errors");
            $finish;
        end
    end

    task automatic push_req(logic [REQ_TYPE_W-1:0] kind, logic [SLOT_ID_W-1:0] slot,
                            logic [REP_ID_W-1:0] rep_id, logic attach,
                            logic [STATUS_W-1:0] new_st);
        request_t r;
        r.kind   = kind;
        r.slot   = slot;
        r.rep_id = rep_id;
        r.attach = attach;
        r.new_st = new_st;
        pending_requests.push_back(r);
    endtask

    // mostly well-formed traffic on a few busy slots, with noise mixed in
    task automatic add_traffic(int unsigned count);
        int unsigned pick;
        logic [SLOT_ID_W-1:0] s;
        logic [REQ_TYPE_W-1:0] kind;
        logic [REP_ID_W-1:0] rep;
        logic [STATUS_W-1:0] nst;
        repeat (count)
        begin
            s = SLOT_ID_W'(($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(15));
            rep = {{(REP_ID_W-SLOT_ID_W){1'b0}}, s};
            nst = STATUS_W'($urandom_range(ST_DEAD));
            pick = $urandom_range(99);
            if (pick < 8)
                kind = REQ_REGISTER;
            else if (pick < 48)
                kind = REQ_TICK;
            else if (pick < 53)
                kind = REQ_RESTART;
            else if (pick < 88)
            begin
                kind = REQ_CHECK;
                if ($urandom_range(99) < 20)
                    rep = REP_ID_W'($urandom_range(0, 65535));
            end
            else if (pick < 95)
            begin
                kind = REQ_SET_STAT;
                if ($urandom_range(99) < 15)
                    nst = STATUS_W'($urandom_range(ST_DEAD + 1, CODE_MAX));
            end
            else
                kind = REQ_TYPE_W'($urandom_range(REQ_SET_STAT + 1, CODE_MAX));
            if (kind != REQ_CHECK && $urandom_range(99) < 30)
                rep = REP_ID_W'($urandom_range(0, 65535));
            push_req(kind, s, rep, ($urandom_range(99) < 80), nst);
        end
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || holding || expected_records.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == CFG_TICK_LIMIT)
            tick_limit_cfg = value;
        else
            max_fail_cfg = value[FAILS_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_limits(logic [LIMIT_W-1:0] limit, logic [FAILS_W-1:0] max_fail);
        drain();
        write_reg(CFG_TICK_LIMIT, limit);
        write_reg(CFG_MAX_FAILURES, {{(CFG_DATA_W-FAILS_W){1'b0}}, max_fail});
    endtask

    initial
    begin
        for (int i = 0; i < 16; i++)
        begin
            slot_live[i]   = 1'b0;
            slot_attach[i] = 1'b0;
            slot_status[i] = ST_STARTED;
            slot_fails[i]  = '0;
            slot_since[i]  = '0;
            slot_total[i]  = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset configuration
        push_req(REQ_CHECK, 4'd0, 16'd0, 1'b1, ST_STARTED);
        push_req(REQ_TICK, 4'd15, 16'hFFFF, 1'b0, ST_DEAD);
        push_req(REQ_REGISTER, 4'd0, 16'd0, 1'b1, ST_STARTED);
        push_req(REQ_REGISTER, 4'd15, 16'd0, 1'b0, ST_STARTED);
        push_req(REQ_TICK, 4'd0, 16'd0, 1'b0, ST_STARTED);
        push_req(REQ_TICK, 4'd15, 16'd0, 1'b0, ST_STARTED);
        push_req(REQ_CHECK, 4'd0, 16'd0, 1'b0, ST_STARTED);
        push_req(REQ_CHECK, 4'd15, 16'd15, 1'b0, ST_STARTED);
        push_req(REQ_CHECK, 4'd0, 16'h8000, 1'b0, ST_STARTED);
        push_req(REQ_CHECK, 4'd0, 16'h7FFF, 1'b0, ST_STARTED);
        push_req(REQ_SET_STAT, 4'd0, 16'd0, 1'b0, ST_KILLED);
        push_req(REQ_SET_STAT, 4'd0, 16'd0, 1'b0, ST_DEAD);
        push_req(REQ_SET_STAT, 4'd0, 16'd0, 1'b0, CODE_MAX);
        push_req(REQ_TYPE_W'(REQ_SET_STAT + 1), 4'd0, 16'd0, 1'b1, ST_STARTED);
        push_req(CODE_MAX, 4'd15, 16'd0, 1'b1, CODE_MAX);
        push_req(REQ_RESTART, 4'd0, 16'd0, 1'b0, ST_STARTED);
        repeat (5) push_req(REQ_CHECK, 4'd0, 16'hFFFF, 1'b0, ST_STARTED);
        push_req(REQ_REGISTER, 4'd0, 16'd0, 1'b1, ST_STARTED);
        push_req(REQ_SET_STAT, 4'd7, 16'd0, 1'b0, ST_OK);

        // zero limit: any tick since the last check is late; one failure restarts
        set_limits(16'd0, 8'd1);
        push_req(REQ_REGISTER, 4'd2, 16'd0, 1'b1, ST_STARTED);
        push_req(REQ_CHECK, 4'd2, 16'd2, 1'b0, ST_STARTED);
        push_req(REQ_TICK, 4'd2, 16'd0, 1'b0, ST_STARTED);
        push_req(REQ_CHECK, 4'd2, 16'd2, 1'b0, ST_STARTED);
        add_traffic(SEG_ITEMS);

        set_limits(16'd3, 8'd3);
        add_traffic(SEG_ITEMS);

        drain();
        send_idle_pct = 70;
        recv_idle_pct = 20;
        set_limits(16'hFFFF, 8'hFF);
        add_traffic(SEG_ITEMS);

        set_limits(16'd10, 8'd2);
        add_traffic(SEG_ITEMS);

        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limits(16'd1, 8'hFF);
        add_traffic(SEG_ITEMS);

        // checked one tick over the limit, then exactly at the limit
        set_limits(16'd20, 8'd4);
        push_req(REQ_REGISTER, 4'd9, 16'd0, 1'b1, ST_STARTED);
        repeat (21) push_req(REQ_TICK, 4'd9, 16'd0, 1'b0, ST_STARTED);
        push_req(REQ_CHECK, 4'd9, 16'd9, 1'b0, ST_STARTED);
        repeat (20) push_req(REQ_TICK, 4'd9, 16'd0, 1'b0, ST_STARTED);
        push_req(REQ_CHECK, 4'd9, 16'd9, 1'b0, ST_STARTED);

        set_limits(16'd5, 8'd4);
        add_traffic(SEG_ITEMS);

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("multi_channel_heartbeat_watchdog_core_tb: clean");
        else
            $display("multi_channel_heartbeat_watchdog_core_tb: errors");
        $finish;
    end

endmodule
